@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rng core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/mclfr_pkg.sv @@
// ----------------------------------------------------------------------------
// mclfr_pkg
// types and constants shared by the lagged fibonacci rng controller and datapath
// ----------------------------------------------------------------------------
package mclfr_pkg;

  localparam int LANE_W    = 16;
  localparam int WORD_W    = 4 * LANE_W;
  localparam int PTR_W     = 6;
  localparam int SEED_W    = 32;
  localparam int LAG_LONG  = 55;
  localparam int LAG_SHORT = 24;

  localparam logic [PTR_W-1:0]  J_START   = 6'd23;
  localparam logic [PTR_W-1:0]  PTR_LAST  = 6'd54;
  localparam logic [PTR_W-1:0]  K_OFFSET  = 6'd31;
  localparam logic [PTR_W-1:0]  K_WRAP    = PTR_W'(LAG_SHORT);
  localparam logic [SEED_W-1:0] SEED_MULT = 32'd3141592621;

  typedef enum logic [1:0] {
    LANE_0 = 2'd0,
    LANE_1 = 2'd1,
    LANE_2 = 2'd2
  } lane_sel_t;

  typedef struct packed {
    logic      accept;
    logic      draw_addr;
    logic      draw_sum;
    logic      out_zero;
    logic      out_reseed;
    logic      fill_init;
    logic      seed_load;
    logic      seed_adv;
    lane_sel_t lane_sel;
    logic      fill_write;
  } cmd_t;

  typedef struct packed {
    logic ctx_ok;
    logic word_last;
    logic ctx_last;
  } sts_t;

endpackage

@@ rtl/core/mclfr_dpath.sv @@
// ----------------------------------------------------------------------------
// mclfr_dpath
// lag table, pointer store, seed sequence and result registers
// ----------------------------------------------------------------------------
module mclfr_dpath #(
  parameter int NUM_CONTEXTS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mclfr_pkg::cmd_t                     cmd,
  output mclfr_pkg::sts_t                     sts,
  input  logic                                cfg_valid,
  input  logic [mclfr_pkg::SEED_W-1:0]        cfg_data,
  input  logic [4:0]                          context_req,
  output logic [mclfr_pkg::LANE_W-1:0]        lane0,
  output logic [mclfr_pkg::LANE_W-1:0]        lane1,
  output logic [mclfr_pkg::LANE_W-1:0]        lane2,
  output logic [mclfr_pkg::LANE_W-1:0]        lane3,
  output logic                                reseed_done,
  output logic                                done
);
  import mclfr_pkg::*;

  localparam int CTX_W  = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam int DEPTH  = NUM_CONTEXTS * LAG_LONG;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [SEED_W-1:0] base_seed;

  // table memory
  logic [WORD_W-1:0] lag_table [DEPTH];
  logic [WORD_W-1:0] rd_j;
  logic [WORD_W-1:0] rd_k;
  logic [ADDR_W-1:0] ra_j;
  logic [ADDR_W-1:0] ra_k;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [WORD_W-1:0] mem_wd;

  // pointer store
  logic [PTR_W-1:0] ptr_mem [NUM_CONTEXTS];
  logic [NUM_CONTEXTS-1:0] ptr_vld;
  logic [PTR_W-1:0] ptr_rd;
  logic             vld_rd;

  // draw registers
  logic [8:0]        ctx_wide;
  logic [CTX_W-1:0]  ctx_idx;
  logic [CTX_W-1:0]  ctx_reg;
  logic [ADDR_W-1:0] base_reg;
  logic [PTR_W-1:0]  j_cur;
  logic [PTR_W-1:0]  k_cur;
  logic [PTR_W-1:0]  j_reg;
  logic [ADDR_W-1:0] addr_k;
  logic [PTR_W-1:0]  j_dec;
  logic [WORD_W-1:0] sum;

  // fill registers
  logic [SEED_W-1:0] seed;
  logic [SEED_W-1:0] seed_inc;
  logic [SEED_W-1:0] seed_adv;
  logic [LANE_W-1:0] fl0;
  logic [LANE_W-1:0] fl1;
  logic [LANE_W-1:0] fl2;
  logic [ADDR_W-1:0] fill_addr;
  logic [PTR_W-1:0]  word_cnt;
  logic [CTX_W-1:0]  ctx_cnt;

  assign ctx_wide = {4'b0, context_req};
  assign ctx_idx  = ctx_wide[CTX_W-1:0];

  assign sts.ctx_ok    = (ctx_wide < 9'(NUM_CONTEXTS));
  assign sts.word_last = (word_cnt == PTR_LAST);
  assign sts.ctx_last  = (ctx_cnt == CTX_W'(NUM_CONTEXTS - 1));

  assign j_cur = vld_rd ? ptr_rd : J_START;
  assign k_cur = (j_cur >= K_WRAP) ? (j_cur - K_WRAP) : (j_cur + K_OFFSET);
  assign ra_j  = base_reg + ADDR_W'(j_cur);
  assign ra_k  = base_reg + ADDR_W'(k_cur);
  assign j_dec = (j_reg == '0) ? PTR_LAST : (j_reg - 6'd1);

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      sum[l*LANE_W +: LANE_W] = rd_k[l*LANE_W +: LANE_W] + rd_j[l*LANE_W +: LANE_W];
    end
  end

  assign seed_inc = seed + 32'd1;
  assign seed_adv = seed_inc * SEED_MULT;

  assign mem_we = cmd.fill_write | cmd.draw_sum;
  assign mem_wa = cmd.fill_write ? fill_addr : addr_k;
  assign mem_wd = cmd.fill_write ? {seed[SEED_W-1 -: LANE_W], fl2, fl1, fl0} : sum;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lag_table[mem_wa] <= mem_wd;
    end
    rd_j <= lag_table[ra_j];
    rd_k <= lag_table[ra_k];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ptr_rd <= ptr_mem[ctx_idx];
    end
    if (cmd.draw_sum) begin
      ptr_mem[ctx_reg] <= j_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr_vld   <= '0;
      base_seed <= '0;
      done      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        base_seed <= cfg_data;
      end
      if (cmd.fill_init) begin
        ptr_vld <= '0;
      end else if (cmd.draw_sum) begin
        ptr_vld[ctx_reg] <= 1'b1;
      end
      done <= cmd.draw_sum | cmd.out_zero | cmd.out_reseed;
    end
  end

  // draw path
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ctx_reg  <= ctx_idx;
      vld_rd   <= ptr_vld[ctx_idx];
      base_reg <= ADDR_W'(ctx_idx) * ADDR_W'(LAG_LONG);
    end
    if (cmd.draw_addr) begin
      j_reg  <= j_cur;
      addr_k <= ra_k;
    end
  end

  // fill path
  always_ff @(posedge clk) begin
    if (cmd.fill_init) begin
      fill_addr <= '0;
      word_cnt  <= '0;
      ctx_cnt   <= '0;
    end else if (cmd.fill_write) begin
      fill_addr <= fill_addr + ADDR_W'(1);
      if (sts.word_last) begin
        word_cnt <= '0;
        ctx_cnt  <= ctx_cnt + CTX_W'(1);
      end else begin
        word_cnt <= word_cnt + 6'd1;
      end
    end
    if (cmd.seed_load) begin
      seed <= base_seed + SEED_W'(ctx_cnt);
    end else if (cmd.seed_adv) begin
      seed <= seed_adv;
      case (cmd.lane_sel)
        LANE_0:  fl0 <= seed[SEED_W-1 -: LANE_W];
        LANE_1:  fl1 <= seed[SEED_W-1 -: LANE_W];
        LANE_2:  fl2 <= seed[SEED_W-1 -: LANE_W];
        default: fl2 <= seed[SEED_W-1 -: LANE_W];
      endcase
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.draw_sum) begin
      lane0       <= sum[0*LANE_W +: LANE_W];
      lane1       <= sum[1*LANE_W +: LANE_W];
      lane2       <= sum[2*LANE_W +: LANE_W];
      lane3       <= sum[3*LANE_W +: LANE_W];
      reseed_done <= 1'b0;
    end else if (cmd.out_zero | cmd.out_reseed) begin
      lane0       <= '0;
      lane1       <= '0;
      lane2       <= '0;
      lane3       <= '0;
      reseed_done <= cmd.out_reseed;
    end
  end

endmodule

@@ rtl/core/mclfr_ctrl.sv @@
// ----------------------------------------------------------------------------
// mclfr_ctrl
// sequencer for draw and reseed items
// ----------------------------------------------------------------------------
module mclfr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            kind,
  output logic            busy,
  input  mclfr_pkg::sts_t sts,
  output mclfr_pkg::cmd_t cmd
);
  import mclfr_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    D_ADDR,
    D_SUM,
    R_LOAD,
    R_L0,
    R_L1,
    R_L2,
    R_WR
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (start) begin
          if (kind) begin
            cmd.fill_init = 1'b1;
            state_next    = R_LOAD;
          end else if (sts.ctx_ok) begin
            cmd.accept = 1'b1;
            state_next = D_ADDR;
          end else begin
            cmd.out_zero = 1'b1;
          end
        end
      end
      D_ADDR: begin
        cmd.draw_addr = 1'b1;
        state_next    = D_SUM;
      end
      D_SUM: begin
        cmd.draw_sum = 1'b1;
        state_next   = IDLE;
      end
      R_LOAD: begin
        cmd.seed_load = 1'b1;
        state_next    = R_L0;
      end
      R_L0: begin
        cmd.seed_adv = 1'b1;
        cmd.lane_sel = LANE_0;
        state_next   = R_L1;
      end
      R_L1: begin
        cmd.seed_adv = 1'b1;
        cmd.lane_sel = LANE_1;
        state_next   = R_L2;
      end
      R_L2: begin
        cmd.seed_adv = 1'b1;
        cmd.lane_sel = LANE_2;
        state_next   = R_WR;
      end
      R_WR: begin
        cmd.fill_write = 1'b1;
        if (sts.word_last && sts.ctx_last) begin
          cmd.out_reseed = 1'b1;
          state_next     = IDLE;
        end else if (sts.word_last) begin
          state_next = R_LOAD;
        end else begin
          state_next = R_L0;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/core/multi_context_lagged_fibonacci_rng.sv @@
// ----------------------------------------------------------------------------
// multi_context_lagged_fibonacci_rng
// 32-context four-lane additive lagged fibonacci generator, lags 24 and 55
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; each item gives one
// result, shown for a single cycle with done high, and the receiver cannot
// stall it. A draw goes from acceptance to done through pointer read,
// table read at both lags, then sum and write-back through the single write
// port of the lag table. A draw for a context index of NUM_CONTEXTS or more
// answers with zero lanes in the cycle after it is taken. A reseed walks the
// whole table through one seed multiplier, three multiplies and one write
// per word, and then gives done with reseed_done high. Draws are meaningful
// only after a reseed. The user must write base_seed through cfg_valid and
// cfg_data only while the block is idle; the block does not enforce it.
module multi_context_lagged_fibonacci_rng #(
  parameter int NUM_CONTEXTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [4:0]  context_req,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output logic [15:0] lane0,
  output logic [15:0] lane1,
  output logic [15:0] lane2,
  output logic [15:0] lane3,
  output logic        reseed_done,
  output logic        done
);
  import mclfr_pkg::*;

  `include "assert_macros.svh"

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  mclfr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  mclfr_dpath #(
    .NUM_CONTEXTS (NUM_CONTEXTS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_valid   (cfg_valid & cfg_ready),
    .cfg_data    (cfg_data),
    .context_req (context_req),
    .lane0       (lane0),
    .lane1       (lane1),
    .lane2       (lane2),
    .lane3       (lane3),
    .reseed_done (reseed_done),
    .done        (done)
  );

  // a reseed keeps the block busy
  `ASSERT_NEXT(a_reseed_busy, clk, rst, start && !busy && kind, busy)

  // a reseed acknowledge carries zero lanes
  `ASSERT_NOW(a_reseed_zero, clk, rst, done && reseed_done, (lane0 | lane1 | lane2 | lane3) == '0)

  // a result only follows work in the previous cycle
  `ASSERT_NOW(a_done_cause, clk, rst, done, $past(busy) || $past(start))

endmodule

@@ tb/sv/tb_multi_context_lagged_fibonacci_rng.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_context_lagged_fibonacci_rng
// self-checking bench for the 32-context lagged fibonacci rng
// ----------------------------------------------------------------------------
// A plan of draws, reseeds, base_seed writes and drain points is queued at
// time zero and played by a driver on the falling edge. A monitor on the
// rising edge keeps a shadow copy of every context's 55-word table and j
// pointer. It predicts each accepted item and compares every done result
// with the oldest prediction, lane by lane.
// ----------------------------------------------------------------------------
module tb_multi_context_lagged_fibonacci_rng;
  import mclfr_pkg::*;

  localparam int NCTX = 32;
  localparam int IDLE_PCT = 8;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_DRAWS = 288;
  localparam bit KIND_DRAW = 1'b0;
  localparam bit KIND_RESEED = 1'b1;

  typedef enum logic [1:0] {
    STEP_ITEM,
    STEP_CFG,
    STEP_DRAIN
  } step_kind_t;

  typedef struct {
    step_kind_t op;
    bit         kind;
    bit [4:0]   ctx;
    bit [31:0]  seed;
    bit         steady;
  } plan_step_t;

  typedef struct packed {
    bit [3:0][LANE_W-1:0] lanes;
    bit                   reseed_done;
  } rng_word_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              kind = 1'b0;
  logic [4:0]        context_req = 5'd0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [31:0]       cfg_data = 32'd0;
  logic [15:0]       lane0;
  logic [15:0]       lane1;
  logic [15:0]       lane2;
  logic [15:0]       lane3;
  logic              reseed_done;
  logic              done;

  plan_step_t        plan[$];
  rng_word_t         due_words[$];

  bit [3:0][LANE_W-1:0] lag_mem [NCTX*LAG_LONG];
  bit [PTR_W-1:0]       j_ptr [NCTX];
  bit [SEED_W-1:0]      seed_reg = '0;

  logic              item_taken = 1'b0;
  logic              cfg_taken = 1'b0;
  logic              nx_start;
  logic              nx_cfg_valid;
  plan_step_t        step;
  int                quiet_cycles = 0;
  rng_word_t         want;
  logic [3:0][15:0]  got;
  int                errors = 0;
  int                draws_seen = 0;
  int                reseeds_seen = 0;
  int                seed_writes = 0;

  multi_context_lagged_fibonacci_rng #(
    .NUM_CONTEXTS(NCTX)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .context_req(context_req),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .lane0(lane0),
    .lane1(lane1),
    .lane2(lane2),
    .lane3(lane3),
    .reseed_done(reseed_done),
    .done(done)
  );

  always #5 clk = ~clk;

  initial begin
    for (int c = 0; c < NCTX; c++) j_ptr[c] = J_START;
  end

  // shadow generator: one accepted item, one predicted result
  task automatic advance_generator(input bit is_reseed, input bit [4:0] ctx);
    rng_word_t     w;
    bit [31:0]     s;
    int            base;
    int            jj;
    int            kk;
    w = '0;
    if (is_reseed) begin
      for (int c = 0; c < NCTX; c++) begin
        s = seed_reg + SEED_W'(c);
        for (int wd = 0; wd < LAG_LONG; wd++) begin
          for (int l = 0; l < 4; l++) begin
            if (l != 0) s = (s + 32'd1) * SEED_MULT;
            lag_mem[c*LAG_LONG + wd][l] = s[31:16];
          end
        end
        j_ptr[c] = J_START;
      end
      w.reseed_done = 1'b1;
    end else begin
      base = int'(ctx) * LAG_LONG;
      jj = int'(j_ptr[ctx]);
      kk = (jj + int'(K_OFFSET)) % LAG_LONG;
      for (int l = 0; l < 4; l++) begin
        lag_mem[base + kk][l] = lag_mem[base + kk][l] + lag_mem[base + jj][l];
        w.lanes[l] = lag_mem[base + kk][l];
      end
      j_ptr[ctx] = (jj == 0) ? PTR_LAST : PTR_W'(jj - 1);
    end
    due_words.push_back(w);
  endtask

  // monitor: check results first, then predict the item taken at this edge
  always @(posedge clk) begin
    item_taken <= !rst && start && !busy;
    cfg_taken <= !rst && cfg_valid && cfg_ready;
    if (!rst) begin
      if (done === 1'b1) begin
        got = {lane3, lane2, lane1, lane0};
        if (due_words.size() == 0) begin
          $display("%0t: unexpected result lanes %h reseed_done %b", $time, got, reseed_done);
          errors++;
        end else begin
          want = due_words.pop_front();
          for (int l = 0; l < 4; l++) begin
            if (got[l] !== want.lanes[l]) begin
              $display("%0t: lane%0d mismatch, expected %h actual %h",
                       $time, l, want.lanes[l], got[l]);
              errors++;
            end
          end
          if (reseed_done !== want.reseed_done) begin
            $display("%0t: reseed_done mismatch, expected %b actual %b",
                     $time, want.reseed_done, reseed_done);
            errors++;
          end
          if (want.reseed_done) reseeds_seen++;
          else draws_seen++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        seed_reg = cfg_data;
        seed_writes++;
      end
      if (start && !busy) advance_generator(kind, context_req);
    end
  end

  // driver: plays the plan on the falling edge
  always @(negedge clk) begin
    nx_start = start;
    nx_cfg_valid = cfg_valid;
    if (!rst) begin
      if (item_taken) nx_start = 1'b0;
      if (cfg_taken) nx_cfg_valid = 1'b0;
      if (!nx_start && !nx_cfg_valid && plan.size() != 0) begin
        step = plan[0];
        case (step.op)
          STEP_ITEM: begin
            if (step.steady || $urandom_range(0, 99) >= IDLE_PCT) begin
              nx_start = 1'b1;
              kind <= step.kind;
              context_req <= step.ctx;
              step = plan.pop_front();
            end
          end
          STEP_CFG: begin
            if (due_words.size() != 0) begin
              quiet_cycles = 0;
            end else if (quiet_cycles < SETTLE_CYCLES) begin
              quiet_cycles++;
            end else begin
              nx_cfg_valid = 1'b1;
              cfg_data <= step.seed;
              quiet_cycles = 0;
              step = plan.pop_front();
            end
          end
          STEP_DRAIN: begin
            if (due_words.size() == 0) step = plan.pop_front();
          end
          default: begin
            step = plan.pop_front();
          end
        endcase
      end
    end
    start <= nx_start;
    cfg_valid <= nx_cfg_valid;
  end

  task automatic push_item(input bit k, input bit [4:0] ctx, input bit steady);
    plan_step_t p;
    p.op = STEP_ITEM;
    p.kind = k;
    p.ctx = ctx;
    p.seed = '0;
    p.steady = steady;
    plan.push_back(p);
  endtask

  task automatic push_cfg(input bit [31:0] seed);
    plan_step_t p;
    p.op = STEP_CFG;
    p.kind = KIND_DRAW;
    p.ctx = '0;
    p.seed = seed;
    p.steady = 1'b0;
    plan.push_back(p);
  endtask

  task automatic push_drain();
    plan_step_t p;
    p.op = STEP_DRAIN;
    p.kind = KIND_DRAW;
    p.ctx = '0;
    p.seed = '0;
    p.steady = 1'b0;
    plan.push_back(p);
  endtask

  initial begin
    bit [31:0] phase_seed;
    bit        focus;
    bit [4:0]  ctx_a;
    bit [4:0]  ctx_b;
    bit [4:0]  ctx;

    // directed part
    push_cfg(32'h0000_0000);
    push_item(KIND_RESEED, 5'd0, 1'b0);
    push_item(KIND_DRAW, 5'd0, 1'b0);
    push_item(KIND_DRAW, 5'd31, 1'b0);
    push_item(KIND_DRAW, 5'd0, 1'b1);
    push_item(KIND_DRAW, 5'd0, 1'b1);
    push_item(KIND_DRAW, 5'd16, 1'b0);
    push_item(KIND_DRAW, 5'd31, 1'b0);
    push_drain();
    push_cfg(32'hFFFF_FFFF);
    push_item(KIND_RESEED, 5'd31, 1'b0);
    push_item(KIND_DRAW, 5'd0, 1'b1);
    push_item(KIND_DRAW, 5'd31, 1'b1);
    push_item(KIND_DRAW, 5'd31, 1'b1);
    push_item(KIND_DRAW, 5'd1, 1'b0);
    // reseed with the same seed resets tables and pointers
    push_item(KIND_RESEED, 5'd10, 1'b0);
    push_item(KIND_DRAW, 5'd0, 1'b0);
    push_item(KIND_DRAW, 5'd21, 1'b0);

    // random phases
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: phase_seed = 32'hFFFF_FFF0;
        2: phase_seed = 32'h8000_0000;
        4: phase_seed = 32'h0000_0001;
        default: phase_seed = $urandom;
      endcase
      push_cfg(phase_seed);
      push_item(KIND_RESEED, 5'($urandom_range(0, 31)), 1'b0);
      focus = p[0];
      ctx_a = 5'($urandom_range(0, 31));
      ctx_b = 5'($urandom_range(0, 31));
      for (int i = 0; i < PHASE_DRAWS; i++) begin
        if ($urandom_range(0, 249) == 0) begin
          push_item(KIND_RESEED, 5'($urandom_range(0, 31)), p == 2);
        end else begin
          if ($urandom_range(0, 99) == 0) push_drain();
          if (focus) ctx = $urandom_range(0, 1) ? ctx_a : ctx_b;
          else ctx = 5'($urandom_range(0, 31));
          push_item(KIND_DRAW, ctx, p == 2);
        end
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (plan.size() != 0 || start || cfg_valid || due_words.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES + 8) @(posedge clk);

    $display("covered %0d draws and %0d reseeds across %0d base_seed writes, %0d errors",
             draws_seen, reseeds_seen, seed_writes, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("timeout with %0d results outstanding", due_words.size());
    $display("FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/mclfr_pkg.sv
rtl/core/mclfr_dpath.sv
rtl/core/mclfr_ctrl.sv
rtl/core/multi_context_lagged_fibonacci_rng.sv
tb/sv/tb_multi_context_lagged_fibonacci_rng.sv
